>>> hw/rtl/dps_pkg.sv
// Shared types and constants for the dynamic priority scheduler.
`default_nettype none
package dps_pkg;

  localparam int MAX_PROCS_DEF = 8;
  localparam int ID_W          = 8;
  localparam int TIME_W        = 10;
  localparam int SPRIO_W       = 7;
  localparam int PRIO_W        = 12;
  localparam int STATUS_W      = 3;

  localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED = 3'd0,
    ST_FULL  = 3'd1,
    ST_ZERO  = 3'd2,
    ST_RAN   = 3'd3,
    ST_IDLE  = 3'd4
  } status_t;

  typedef enum logic {
    MODE_ADD  = 1'b0,
    MODE_TICK = 1'b1
  } mode_t;

  // what every cell of the chain does this cycle
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_ADD    = 2'd1,
    OP_SHIFT  = 2'd2,
    OP_REINS  = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic                     valid;
    logic [ID_W-1:0]          ident;
    logic [TIME_W-1:0]        time_left;
    logic signed [PRIO_W-1:0] prio;
  } slot_t;

  typedef struct packed {
    logic               mode;
    logic [ID_W-1:0]    proc_id;
    logic [TIME_W-1:0]  service_ticks;
    logic [SPRIO_W-1:0] start_priority;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic [ID_W-1:0]          run_id;
    logic [TIME_W-1:0]        remaining_time;
    logic signed [PRIO_W-1:0] priority_now;
    logic                     finished;
  } res_t;

endpackage
`default_nettype wire

>>> hw/rtl/dps_cell.sv
// One slot of the sorted ready queue, exchanging entries with its neighbors.
`default_nettype none
module dps_cell (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire dps_pkg::cell_op_t                 op,
  input  wire logic signed [dps_pkg::PRIO_W-1:0] key_prio,
  input  wire dps_pkg::slot_t                    ins,
  input  wire dps_pkg::slot_t                    left,
  input  wire dps_pkg::slot_t                    right,
  input  wire logic                              ge_left,
  input  wire logic                              ge_right,
  output dps_pkg::slot_t                         q,
  output logic                                   ge
);

  dps_pkg::slot_t slot;
  dps_pkg::slot_t slot_next;

  assign q  = slot;
  assign ge = slot.valid && (slot.prio >= key_prio);

  always_comb begin
    slot_next = slot;
    unique case (op)
      dps_pkg::OP_HOLD: begin
        slot_next = slot;
      end
      dps_pkg::OP_ADD: begin
        priority if (ge)   slot_next = slot;
        else if (ge_left)  slot_next = ins;
        else               slot_next = left;
      end
      dps_pkg::OP_SHIFT: begin
        slot_next = right;
      end
      dps_pkg::OP_REINS: begin
        priority if (ge_right) slot_next = right;
        else if (ge)           slot_next = ins;
        else                   slot_next = slot;
      end
      default: slot_next = slot;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= slot_next.valid;
    end
    slot.ident     <= slot_next.ident;
    slot.time_left <= slot_next.time_left;
    slot.prio      <= slot_next.prio;
  end

endmodule
`default_nettype wire

>>> hw/rtl/dynamic_priority_scheduler_top.sv
// Top level of the dynamic priority scheduler: cell chain and request control.
//
// Usage: requests enter on req_valid/req_ready/req_data. Mode add inserts a
// process behind every queued entry of equal or higher priority; mode tick
// runs the head process, ages it by one priority step and one time unit, and
// either retires it or re-sorts it behind its equals. Each request yields
// exactly one result on res_valid/res_ready/res_data.
// The result is registered at the edge that takes the request. Throughput is
// one request per cycle while the result side keeps up; every cell of the chain
// compares against the broadcast key in parallel and moves in that cycle.
// The result register decouples the sides: a new request is taken whenever
// the register is empty or is being drained in the same cycle. While the
// receiver stalls with a result pending, req_ready stays low and the queue
// holds. Reset empties the queue (all slot valid bits clear) and drops any
// pending result; no clearing pass is needed.
`default_nettype none
module dynamic_priority_scheduler_top #(
  parameter int MAX_PROCS = dps_pkg::MAX_PROCS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire dps_pkg::req_t req_data,
  output logic               res_valid,
  input  wire logic          res_ready,
  output dps_pkg::res_t      res_data
);

  localparam int PAD_W = dps_pkg::PRIO_W - dps_pkg::SPRIO_W;

  dps_pkg::slot_t q_chain  [MAX_PROCS];
  logic           ge_chain [MAX_PROCS];

  dps_pkg::cell_op_t                 op;
  logic signed [dps_pkg::PRIO_W-1:0] key_prio;
  dps_pkg::slot_t                    ins;
  dps_pkg::res_t                     res_next;
  dps_pkg::slot_t                    head;
  dps_pkg::slot_t                    empty_slot;
  logic [dps_pkg::TIME_W-1:0]        head_time;
  logic signed [dps_pkg::PRIO_W-1:0] head_prio;
  logic signed [dps_pkg::PRIO_W-1:0] add_prio;
  logic                              accept;
  logic                              full;
  logic                              empty;

  assign req_ready  = !res_valid || res_ready;
  assign accept     = req_valid && req_ready;
  assign head       = q_chain[0];
  assign full       = q_chain[MAX_PROCS-1].valid;
  assign empty      = !head.valid;
  assign head_time  = head.time_left - dps_pkg::TIME_W'(1);
  assign head_prio  = (head.prio == dps_pkg::PRIO_MIN) ? head.prio
                                                       : head.prio - dps_pkg::PRIO_W'(1);
  assign add_prio   = $signed({{PAD_W{1'b0}}, req_data.start_priority});
  assign empty_slot = '0;

  always_comb begin
    op                      = dps_pkg::OP_HOLD;
    key_prio                = add_prio;
    ins.valid               = 1'b1;
    ins.ident               = req_data.proc_id;
    ins.time_left           = req_data.service_ticks;
    ins.prio                = add_prio;
    res_next.status         = dps_pkg::ST_ADDED;
    res_next.run_id         = req_data.proc_id;
    res_next.remaining_time = req_data.service_ticks;
    res_next.priority_now   = add_prio;
    res_next.finished       = 1'b0;
    if (req_data.mode == dps_pkg::MODE_ADD) begin
      priority if (full) begin
        res_next.status = dps_pkg::ST_FULL;
      end else if (req_data.service_ticks == '0) begin
        res_next.status = dps_pkg::ST_ZERO;
      end else begin
        op = accept ? dps_pkg::OP_ADD : dps_pkg::OP_HOLD;
      end
    end else if (empty) begin
      res_next = '{status: dps_pkg::ST_IDLE, default: '0};
    end else begin
      key_prio                = head_prio;
      ins.ident               = head.ident;
      ins.time_left           = head_time;
      ins.prio                = head_prio;
      res_next.status         = dps_pkg::ST_RAN;
      res_next.run_id         = head.ident;
      res_next.remaining_time = head_time;
      res_next.priority_now   = head_prio;
      res_next.finished       = (head_time == '0);
      if (accept) begin
        op = (head_time == '0) ? dps_pkg::OP_SHIFT : dps_pkg::OP_REINS;
      end
    end
  end

  for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
    dps_pkg::slot_t left_slot;
    dps_pkg::slot_t right_slot;
    logic           left_ge;
    logic           right_ge;

    if (i == 0) begin : g_first
      assign left_slot = ins;
      assign left_ge   = 1'b1;
    end else begin : g_mid_l
      assign left_slot = q_chain[i-1];
      assign left_ge   = ge_chain[i-1];
    end

    if (i == MAX_PROCS - 1) begin : g_last
      assign right_slot = empty_slot;
      assign right_ge   = 1'b0;
    end else begin : g_mid_r
      assign right_slot = q_chain[i+1];
      assign right_ge   = ge_chain[i+1];
    end

    dps_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .op       (op),
      .key_prio (key_prio),
      .ins      (ins),
      .left     (left_slot),
      .right    (right_slot),
      .ge_left  (left_ge),
      .ge_right (right_ge),
      .q        (q_chain[i]),
      .ge       (ge_chain[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (accept) begin
      res_data <= res_next;
    end
  end

endmodule
`default_nettype wire

>>> bench/dynamic_priority_scheduler_top_test.sv
// Self-checking testbench for the dynamic priority scheduler top level.
`default_nettype none
module dynamic_priority_scheduler_top_test;

  localparam int NUM_PROCS    = dps_pkg::MAX_PROCS_DEF;
  localparam int RANDOM_REQS  = 1928;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 250;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  dps_pkg::req_t req_data = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  dps_pkg::res_t res_data;

  dps_pkg::req_t  pending_reqs[$];
  dps_pkg::res_t  due_results[$];
  dps_pkg::slot_t ready_queue[$];

  int reqs_taken = 0;
  int results_seen = 0;
  int fails = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  dynamic_priority_scheduler_top #(.MAX_PROCS(NUM_PROCS)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data(req_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data(res_data)
  );

  always #2 clk = ~clk;

  // no idling on either side through this stretch of requests
  function automatic bit calm();
    return reqs_taken >= 1000 && reqs_taken < 1300;
  endfunction

  // queue kept behind all entries of equal or higher priority
  function automatic void enqueue(dps_pkg::slot_t s);
    int pos;
    pos = 0;
    while (pos < ready_queue.size() && $signed(ready_queue[pos].prio) >= $signed(s.prio))
      pos++;
    ready_queue.insert(pos, s);
  endfunction

  function automatic dps_pkg::res_t schedule_step(dps_pkg::req_t r);
    dps_pkg::res_t  o;
    dps_pkg::slot_t s;
    o = '0;
    o.finished = 1'b0;
    if (r.mode == dps_pkg::MODE_ADD) begin
      o.run_id = r.proc_id;
      o.remaining_time = r.service_ticks;
      o.priority_now = {{(dps_pkg::PRIO_W-dps_pkg::SPRIO_W){1'b0}}, r.start_priority};
      if (ready_queue.size() >= NUM_PROCS) begin
        o.status = dps_pkg::ST_FULL;
      end else if (r.service_ticks == '0) begin
        o.status = dps_pkg::ST_ZERO;
      end else begin
        o.status = dps_pkg::ST_ADDED;
        s.valid = 1'b1;
        s.ident = o.run_id;
        s.time_left = o.remaining_time;
        s.prio = o.priority_now;
        enqueue(s);
      end
    end else if (ready_queue.size() == 0) begin
      o.status = dps_pkg::ST_IDLE;
    end else begin
      o.status = dps_pkg::ST_RAN;
      s = ready_queue.pop_front();
      if (s.prio != dps_pkg::PRIO_MIN)
        s.prio = s.prio - 1'b1;
      if (s.time_left != '0)
        s.time_left = s.time_left - 1'b1;
      o.run_id = s.ident;
      o.remaining_time = s.time_left;
      o.priority_now = s.prio;
      if (s.time_left == '0) begin
        o.finished = 1'b1;
      end else if (ready_queue.size() > 0 && $signed(s.prio) <= $signed(ready_queue[0].prio)) begin
        enqueue(s);
      end else begin
        ready_queue.push_front(s);
      end
    end
    return o;
  endfunction

  task automatic push_add(int id, int t, int p);
    dps_pkg::req_t r;
    r.mode = dps_pkg::MODE_ADD;
    r.proc_id = id[dps_pkg::ID_W-1:0];
    r.service_ticks = t[dps_pkg::TIME_W-1:0];
    r.start_priority = p[dps_pkg::SPRIO_W-1:0];
    pending_reqs.push_back(r);
  endtask

  task automatic push_tick();
    dps_pkg::req_t r;
    r.mode = dps_pkg::MODE_TICK;
    r.proc_id = dps_pkg::ID_W'($urandom);
    r.service_ticks = dps_pkg::TIME_W'($urandom);
    r.start_priority = dps_pkg::SPRIO_W'($urandom);
    pending_reqs.push_back(r);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  initial begin
    int add_pct;
    int t;
    // empty queue, zero time, extremes, equal-priority FIFO order
    push_tick();
    push_add(0, 0, 0);
    push_add(255, 1023, 126);
    push_add(1, 1, 126);
    push_tick();
    push_tick();
    push_tick();
    // fill to full, then full takes precedence over zero time
    push_add(2, 2, 0);
    push_add(3, 3, 64);
    push_add(4, 1, 64);
    push_add(5, 5, 1);
    push_add(6, 1, 126);
    push_add(7, 4, 100);
    push_add(8, 1, 0);
    push_add(9, 7, 50);
    push_add(10, 0, 50);
    repeat (6) push_tick();

    add_pct = 50;
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i % 50 == 0)
        add_pct = 25 * $urandom_range(3, 1);
      if ($urandom_range(99) < add_pct) begin
        case ($urandom_range(19))
          0:       t = 0;
          1:       t = $urandom_range(1023);
          default: t = $urandom_range(8, 1);
        endcase
        push_add($urandom_range(255), t, $urandom_range(126));
      end else begin
        push_tick();
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
    if (fails == 0) begin
      $display("dynamic_priority_scheduler_top_test passed");
    end else begin
      $display("dynamic_priority_scheduler_top_test failed");
    end
    $finish;
  end

  always @(posedge clk) begin : drive_requests
    logic offer;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      offer = req_valid && !req_ready;
      if (req_valid && req_ready) begin
        due_results.push_back(schedule_step(req_data));
        reqs_taken++;
      end
      if (!offer && pending_reqs.size() != 0 && (calm() || $urandom_range(99) >= 7)) begin
        req_data <= pending_reqs.pop_front();
        offer = 1'b1;
      end
      req_valid <= offer;
    end
  end

  always @(posedge clk) begin : check_results
    dps_pkg::res_t want;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          want = due_results.pop_front();
          check_field("status", int'(want.status), int'(res_data.status));
          check_field("run_id", int'(want.run_id), int'(res_data.run_id));
          check_field("remaining_time", int'(want.remaining_time),
                      int'(res_data.remaining_time));
          check_field("priority_now", int'($signed(want.priority_now)),
                      int'($signed(res_data.priority_now)));
          check_field("finished", int'(want.finished), int'(res_data.finished));
        end
      end
      // one long back-pressure stretch so the request side stalls
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res_ready <= 1'b0;
      end else if (!hold_done && results_seen >= 400) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        res_ready <= 1'b0;
      end else begin
        res_ready <= calm() || $urandom_range(99) >= 7;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((req_valid && req_ready) || (res_valid && res_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("dynamic_priority_scheduler_top_test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
`default_nettype wire
